/* design/bta_pkg.sv */
package bta_pkg;

  // Internal signed width for heap positions and rooms (room reaches 2^31)
  localparam int PW = 34;
  // Statistics accumulators: up to half the heap of rooms below 2^31
  localparam int SUMW = 49;
  localparam int CNTW = 17;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_ALLOC_ZERO,
    OP_REALLOC,
    OP_FREE,
    OP_STATS,
    OP_CHECK,
    OP_WRITE,
    OP_READ
  } op_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NOFIT,
    ST_RANGE,
    ST_CORRUPT
  } status_e;

  // Datapath micro-actions
  typedef enum logic [5:0] {
    A_NOP,
    A_LOAD,
    A_RD_S,
    A_RD_E,
    A_RD_P,
    A_RD_BAM1,
    A_RD_BAI,
    A_RD_BA,
    A_RD_SM1,
    A_TAG,
    A_ADV_RD,
    A_W_S_WORDS,
    A_W_SPLIT1,
    A_W_SPLIT2,
    A_W_E_NLEFT,
    A_W_S_ROOM,
    A_W_E_ROOM,
    A_ZERO,
    A_SET_N_MIN,
    A_INC_I,
    A_W_COPY,
    A_LD_S_BAM1,
    A_W_S_NEGT,
    A_W_E_NEGT,
    A_PREV,
    A_S_FROM_P,
    A_LE,
    A_W_S_MRG,
    A_W_E_MRG,
    A_ACC,
    A_CK_ADV,
    A_W_BA,
    A_LD_RDATA,
    A_OUT
  } act_e;

  typedef struct packed {
    act_e    act;
    logic    set_st;
    status_e st;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic words_zero;
    logic s_in;
    logic p_in;
    logic e_in;
    logic ba_in;
    logic bam1_in;
    logic t_neg;
    logic t_zero;
    logic fit;
    logic split;
    logic rd_neg;
    logic rd_eq_t;
    logic s_pos;
    logic s_end;
    logic i_lt_n;
    logic cp_in;
    logic last_free;
    logic out_free;
  } flags_t;

  // Magnitude of a tag, widened so that the most negative tag stays exact
  function automatic logic signed [PW-1:0] room(input logic signed [31:0] v);
    logic signed [PW-1:0] x;
    x = PW'(v);
    return (x < 0) ? -x : x;
  endfunction

endpackage

/* design/bta_req_if.sv */
interface bta_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic [15:0]        size_bytes;
  logic [10:0]        block_addr;
  logic signed [31:0] write_data;

  modport source (output valid, op, size_bytes, block_addr, write_data, input ready);
  modport sink (input valid, op, size_bytes, block_addr, write_data, output ready);
endinterface

/* design/bta_rsp_if.sv */
interface bta_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [9:0]         addr;
  logic signed [31:0] read_data;
  logic [10:0]        words_allocated;
  logic [10:0]        words_available;
  logic [10:0]        words_overhead;
  logic [9:0]         blocks_used;
  logic [9:0]         blocks_unused;

  modport source (output valid, status, addr, read_data, words_allocated, words_available,
                  words_overhead, blocks_used, blocks_unused, input ready);
  modport sink (input valid, status, addr, read_data, words_allocated, words_available,
                words_overhead, blocks_used, blocks_unused, output ready);
endinterface

/* design/bta_ram.sv */
module bta_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/bta_ctrl.sv */
module bta_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bta_pkg::flags_t flags_i,
  output bta_pkg::cmd_t   cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE, S_DISP,
    S_AL_START, S_AL_TAG, S_AL_DEC, S_SP2, S_SP3, S_SP4, S_AL_CMP, S_AL_W2, S_ALC_OK,
    S_ZERO,
    S_RA_START, S_RA_HDR, S_RA_OS, S_RA_ORR, S_RC_CHK, S_RC_WR,
    S_FR_START, S_FR_HDR, S_FR_DEC, S_FR_TRL, S_FR_W2, S_FR_PREV, S_FR_PS, S_FR_PSC,
    S_FR_PSH, S_FR_NX, S_FR_NXR, S_FR_NXC, S_FR_NXH,
    S_MD0, S_MD1, S_MD2, S_MD3, S_MD4, S_MD5,
    S_ST_RD, S_ST_ACC, S_ST_NX,
    S_CK_CHK, S_CK_TAG, S_CK_DEC, S_CK_TRL,
    S_WR, S_RD, S_RD_D, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   ret_nx_q, ret_nx_d;
  state_e ret_st;

  assign ret_st     = ret_nx_q ? S_FR_NX : S_DONE;
  assign in_ready_o = (state_q == S_IDLE);

  // Next state and command
  always_comb begin
    state_d    = state_q;
    ret_nx_d   = ret_nx_q;
    cmd_o      = '{act: bta_pkg::A_NOP, set_st: 1'b0, st: bta_pkg::ST_OK};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.act = bta_pkg::A_LOAD;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        case (flags_i.op)
          bta_pkg::OP_ALLOC, bta_pkg::OP_ALLOC_ZERO: state_d = S_AL_START;
          bta_pkg::OP_REALLOC: state_d = S_RA_START;
          bta_pkg::OP_FREE:    state_d = S_FR_START;
          bta_pkg::OP_STATS:   state_d = S_ST_RD;
          bta_pkg::OP_CHECK:   state_d = S_CK_CHK;
          bta_pkg::OP_WRITE:   state_d = S_WR;
          default:             state_d = S_RD;
        endcase
      end
      // First-fit search
      S_AL_START: begin
        if (flags_i.words_zero) begin
          cmd_o.set_st = 1'b1; cmd_o.st = bta_pkg::ST_NOFIT; state_d = S_DONE;
        end else begin
          cmd_o.act = bta_pkg::A_RD_S; state_d = S_AL_TAG;
        end
      end
      S_AL_TAG: begin
        cmd_o.act = bta_pkg::A_TAG; state_d = S_AL_DEC;
      end
      S_AL_DEC: begin
        if (flags_i.fit) begin
          if (!flags_i.e_in) begin
            cmd_o.set_st = 1'b1; cmd_o.st = bta_pkg::ST_CORRUPT; state_d = S_DONE;
          end else if (flags_i.split) begin
            cmd_o.act = bta_pkg::A_W_S_WORDS; state_d = S_SP2;
          end else begin
            cmd_o.act = bta_pkg::A_RD_E; state_d = S_AL_CMP;
          end
        end else if (flags_i.p_in) begin
          cmd_o.act = bta_pkg::A_ADV_RD; state_d = S_AL_TAG;
        end else begin
          cmd_o.set_st = 1'b1; cmd_o.st = bta_pkg::ST_NOFIT; state_d = S_DONE;
        end
      end
      S_SP2: begin cmd_o.act = bta_pkg::A_W_SPLIT1;  state_d = S_SP3;    end
      S_SP3: begin cmd_o.act = bta_pkg::A_W_SPLIT2;  state_d = S_SP4;    end
      S_SP4: begin cmd_o.act = bta_pkg::A_W_E_NLEFT; state_d = S_ALC_OK; end
      S_AL_CMP: begin
        if (!flags_i.rd_eq_t) begin
          cmd_o.set_st = 1'b1; cmd_o.st = bta_pkg::ST_CORRUPT; state_d = S_DONE;
        end else begin
          cmd_o.act = bta_pkg::A_W_S_ROOM; state_d = S_AL_W2;
        end
      end
      S_AL_W2: begin cmd_o.act = bta_pkg::A_W_E_ROOM; state_d = S_ALC_OK; end
      S_ALC_OK: begin
        case (flags_i.op)
          bta_pkg::OP_ALLOC:      state_d = S_DONE;
          bta_pkg::OP_ALLOC_ZERO: state_d = S_ZERO;
          default:                state_d = S_RA_OS;
        endcase
      end
      S_ZERO: begin
        if (flags_i.i_lt_n) cmd_o.act = bta_pkg::A_ZERO;
        else                state_d   = S_DONE;
      end
      // Reallocate: check old block, allocate, copy, then free
      S_RA_START: begin
        if (!flags_i.bam1_in) begin
          cmd_o.set_st = 1'b1; cmd_o.st = bta_pkg::ST_RANGE; state_d = S_DONE;
        end else begin
          cmd_o.act = bta_pkg::A_RD_BAM1; state_d = S_RA_HDR;
        end
      end
      S_RA_HDR: begin
        if (flags_i.rd_neg) begin
          cmd_o.set_st = 1'b1; cmd_o.st = bta_pkg::ST_CORRUPT; state_d = S_DONE;
        end else begin
          state_d = S_AL_START;
        end
      end
      S_RA_OS:  begin cmd_o.act = bta_pkg::A_RD_BAM1;   state_d = S_RA_ORR; end
      S_RA_ORR: begin cmd_o.act = bta_pkg::A_SET_N_MIN; state_d = S_RC_CHK; end
      S_RC_CHK: begin
        if (!flags_i.i_lt_n) begin
          state_d = S_FR_START;
        end else if (flags_i.cp_in) begin
          cmd_o.act = bta_pkg::A_RD_BAI; state_d = S_RC_WR;
        end else begin
          cmd_o.act = bta_pkg::A_INC_I;
        end
      end
      S_RC_WR: begin cmd_o.act = bta_pkg::A_W_COPY; state_d = S_RC_CHK; end
      // Free with neighbor merge
      S_FR_START: begin
        if (!flags_i.bam1_in) begin
          cmd_o.set_st = 1'b1; cmd_o.st = bta_pkg::ST_RANGE; state_d = S_DONE;
        end else begin
          cmd_o.act = bta_pkg::A_LD_S_BAM1; state_d = S_FR_HDR;
        end
      end
      S_FR_HDR: begin cmd_o.act = bta_pkg::A_TAG; state_d = S_FR_DEC; end
      S_FR_DEC: begin
        if (flags_i.t_neg || !flags_i.e_in) begin
          cmd_o.set_st = 1'b1; cmd_o.st = bta_pkg::ST_CORRUPT; state_d = S_DONE;
        end else begin
          cmd_o.act = bta_pkg::A_RD_E; state_d = S_FR_TRL;
        end
      end
      S_FR_TRL: begin
        if (flags_i.rd_neg || !flags_i.rd_eq_t) begin
          cmd_o.set_st = 1'b1; cmd_o.st = bta_pkg::ST_CORRUPT; state_d = S_DONE;
        end else begin
          cmd_o.act = bta_pkg::A_W_S_NEGT; state_d = S_FR_W2;
        end
      end
      S_FR_W2: begin cmd_o.act = bta_pkg::A_W_E_NEGT; state_d = S_FR_PREV; end
      S_FR_PREV: begin
        if (flags_i.s_pos) begin
          cmd_o.act = bta_pkg::A_RD_SM1; state_d = S_FR_PS;
        end else begin
          state_d = S_FR_NX;
        end
      end
      S_FR_PS: begin cmd_o.act = bta_pkg::A_PREV; state_d = S_FR_PSC; end
      S_FR_PSC: begin
        if (flags_i.p_in) begin
          cmd_o.act = bta_pkg::A_RD_P; state_d = S_FR_PSH;
        end else begin
          state_d = S_FR_NX;
        end
      end
      S_FR_PSH: begin
        if (flags_i.rd_neg) begin
          cmd_o.act = bta_pkg::A_S_FROM_P; ret_nx_d = 1'b1; state_d = S_MD0;
        end else begin
          state_d = S_FR_NX;
        end
      end
      S_FR_NX:  begin cmd_o.act = bta_pkg::A_RD_S; state_d = S_FR_NXR; end
      S_FR_NXR: begin cmd_o.act = bta_pkg::A_TAG;  state_d = S_FR_NXC; end
      S_FR_NXC: begin
        if (flags_i.p_in) begin
          cmd_o.act = bta_pkg::A_RD_P; state_d = S_FR_NXH;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FR_NXH: begin
        if (flags_i.rd_neg) begin
          ret_nx_d = 1'b0; state_d = S_MD0;
        end else begin
          state_d = S_DONE;
        end
      end
      // Merge the block at s with the block after it
      S_MD0: begin cmd_o.act = bta_pkg::A_RD_S; state_d = S_MD1; end
      S_MD1: begin cmd_o.act = bta_pkg::A_TAG;  state_d = S_MD2; end
      S_MD2: begin
        if (flags_i.p_in) begin
          cmd_o.act = bta_pkg::A_RD_P; state_d = S_MD3;
        end else begin
          state_d = ret_st;
        end
      end
      S_MD3: begin cmd_o.act = bta_pkg::A_LE; state_d = S_MD4; end
      S_MD4: begin
        if (flags_i.e_in) begin
          cmd_o.act = bta_pkg::A_W_S_MRG; state_d = S_MD5;
        end else begin
          state_d = ret_st;
        end
      end
      S_MD5: begin cmd_o.act = bta_pkg::A_W_E_MRG; state_d = ret_st; end
      // Statistics walk
      S_ST_RD:  begin cmd_o.act = bta_pkg::A_RD_S; state_d = S_ST_ACC; end
      S_ST_ACC: begin cmd_o.act = bta_pkg::A_ACC;  state_d = S_ST_NX;  end
      S_ST_NX: begin
        if (flags_i.p_in) begin
          cmd_o.act = bta_pkg::A_ADV_RD; state_d = S_ST_ACC;
        end else begin
          state_d = S_DONE;
        end
      end
      // Consistency walk
      S_CK_CHK: begin
        if (flags_i.s_in) begin
          cmd_o.act = bta_pkg::A_RD_S; state_d = S_CK_TAG;
        end else begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = flags_i.s_end ? bta_pkg::ST_OK : bta_pkg::ST_CORRUPT;
          state_d      = S_DONE;
        end
      end
      S_CK_TAG: begin cmd_o.act = bta_pkg::A_TAG; state_d = S_CK_DEC; end
      S_CK_DEC: begin
        if (flags_i.t_zero || !flags_i.e_in) begin
          cmd_o.set_st = 1'b1; cmd_o.st = bta_pkg::ST_CORRUPT; state_d = S_DONE;
        end else begin
          cmd_o.act = bta_pkg::A_RD_E; state_d = S_CK_TRL;
        end
      end
      S_CK_TRL: begin
        if (!flags_i.rd_eq_t || (flags_i.last_free && flags_i.t_neg)) begin
          cmd_o.set_st = 1'b1; cmd_o.st = bta_pkg::ST_CORRUPT; state_d = S_DONE;
        end else begin
          cmd_o.act = bta_pkg::A_CK_ADV; state_d = S_CK_CHK;
        end
      end
      // Raw word access
      S_WR: begin
        if (flags_i.ba_in) begin
          cmd_o.act = bta_pkg::A_W_BA;
        end else begin
          cmd_o.set_st = 1'b1; cmd_o.st = bta_pkg::ST_RANGE;
        end
        state_d = S_DONE;
      end
      S_RD: begin
        if (flags_i.ba_in) begin
          cmd_o.act = bta_pkg::A_RD_BA; state_d = S_RD_D;
        end else begin
          cmd_o.set_st = 1'b1; cmd_o.st = bta_pkg::ST_RANGE; state_d = S_DONE;
        end
      end
      S_RD_D: begin cmd_o.act = bta_pkg::A_LD_RDATA; state_d = S_DONE; end
      S_DONE: begin
        if (flags_i.out_free) begin
          cmd_o.act = bta_pkg::A_OUT; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_nx_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_nx_q <= ret_nx_d;
    end
  end

endmodule

/* design/bta_dp.sv */
module bta_dp #(
  parameter int HEAP_WORDS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bta_pkg::cmd_t      cmd_i,
  output bta_pkg::flags_t    flags_o,
  input  logic [2:0]         op_i,
  input  logic [15:0]        size_bytes_i,
  input  logic [10:0]        block_addr_i,
  input  logic signed [31:0] write_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [1:0]         status_o,
  output logic [9:0]         addr_o,
  output logic signed [31:0] read_data_o,
  output logic [10:0]        words_allocated_o,
  output logic [10:0]        words_available_o,
  output logic [10:0]        words_overhead_o,
  output logic [9:0]         blocks_used_o,
  output logic [9:0]         blocks_unused_o
);

  localparam int PW   = bta_pkg::PW;
  localparam int SUMW = bta_pkg::SUMW;
  localparam int CNTW = bta_pkg::CNTW;
  localparam int AW   = $clog2(HEAP_WORDS);
  localparam logic signed [PW-1:0] HeapSz = PW'(HEAP_WORDS);
  localparam logic signed [31:0]   EndTag = 32'(2 - HEAP_WORDS);
  localparam logic [AW-1:0]        LastAddr = AW'(HEAP_WORDS - 1);

  function automatic logic in_heap(input logic signed [PW-1:0] a);
    return (a >= 0) && (a < HeapSz);
  endfunction

  function automatic logic [10:0] sat11(input logic signed [SUMW:0] v);
    if (v < 0) return 11'd0;
    if (v > (SUMW+1)'(2047)) return 11'd2047;
    return v[10:0];
  endfunction

  function automatic logic [9:0] sat10(input logic [CNTW-1:0] v);
    return (v > CNTW'(1023)) ? 10'd1023 : v[9:0];
  endfunction

  // Operation registers
  bta_pkg::op_e         op_q;
  logic [14:0]          words_q;
  logic [10:0]          ba_q;
  logic signed [31:0]   wd_q;
  logic signed [PW-1:0] s_q, e_q, p_q, where_q, n_q, i_q;
  logic signed [31:0]   t_q;
  logic [SUMW-1:0]      wa_q, wv_q;
  logic [CNTW-1:0]      bu_q, bf_q;
  logic                 last_free_q;
  bta_pkg::status_e     status_q;
  logic signed [31:0]   rdata_q;

  // Output register
  logic               o_valid_q;
  logic [1:0]         o_status_q;
  logic [9:0]         o_addr_q;
  logic signed [31:0] o_rdata_q;
  logic [10:0]        o_wa_q, o_wv_q, o_wo_q;
  logic [9:0]         o_bu_q, o_bf_q;

  // End tags read as the reset value until first written
  logic f0_q, fn_q, ovr_q;

  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic signed [PW-1:0] mem_pos;
  logic signed [31:0]   mem_wdata;
  logic [31:0]          ram_rdata;
  logic signed [31:0]   rd;
  logic signed [PW-1:0] rd_room, t_room, ba_x, ba_m1, ba_i, wh_i, words_x, left;
  logic signed [31:0]   mrg_tag;
  logic signed [SUMW:0] overhead;

  assign rd      = ovr_q ? EndTag : signed'(ram_rdata);
  assign rd_room = bta_pkg::room(rd);
  assign t_room  = bta_pkg::room(t_q);
  assign ba_x    = signed'(PW'(ba_q));
  assign ba_m1   = ba_x - PW'(1);
  assign ba_i    = ba_x + i_q;
  assign wh_i    = where_q + i_q;
  assign words_x = signed'(PW'(words_q));
  assign left    = t_room - words_x - PW'(2);
  assign mrg_tag = 32'(s_q - e_q + PW'(1));

  // Status flags for the controller
  always_comb begin
    flags_o.op         = op_q;
    flags_o.words_zero = (words_q == '0);
    flags_o.s_in       = in_heap(s_q);
    flags_o.p_in       = in_heap(p_q);
    flags_o.e_in       = in_heap(e_q);
    flags_o.ba_in      = in_heap(ba_x);
    flags_o.bam1_in    = in_heap(ba_m1);
    flags_o.t_neg      = (t_q < 0);
    flags_o.t_zero     = (t_q == '0);
    flags_o.fit        = (t_q < 0) && (words_x <= t_room);
    flags_o.split      = (left > 0);
    flags_o.rd_neg     = (rd < 0);
    flags_o.rd_eq_t    = (rd == t_q);
    flags_o.s_pos      = (s_q > 0);
    flags_o.s_end      = (s_q == HeapSz);
    flags_o.i_lt_n     = (i_q < n_q);
    flags_o.cp_in      = in_heap(ba_i) && in_heap(wh_i);
    flags_o.last_free  = last_free_q;
    flags_o.out_free   = !o_valid_q || out_ready_i;
  end

  // Memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_pos   = s_q;
    mem_wdata = '0;
    case (cmd_i.act)
      bta_pkg::A_RD_E:                        mem_pos = e_q;
      bta_pkg::A_RD_P, bta_pkg::A_ADV_RD:     mem_pos = p_q;
      bta_pkg::A_RD_BAM1, bta_pkg::A_LD_S_BAM1: mem_pos = ba_m1;
      bta_pkg::A_RD_BAI:                      mem_pos = ba_i;
      bta_pkg::A_RD_BA:                       mem_pos = ba_x;
      bta_pkg::A_RD_SM1:                      mem_pos = s_q - PW'(1);
      bta_pkg::A_W_S_WORDS: begin
        mem_we = 1'b1; mem_wdata = 32'(words_x);
      end
      bta_pkg::A_W_SPLIT1: begin
        mem_we = 1'b1; mem_pos = s_q + words_x + PW'(1); mem_wdata = 32'(words_x);
      end
      bta_pkg::A_W_SPLIT2: begin
        mem_we = 1'b1; mem_pos = s_q + words_x + PW'(2); mem_wdata = 32'(-left);
      end
      bta_pkg::A_W_E_NLEFT: begin
        mem_we = 1'b1; mem_pos = e_q; mem_wdata = 32'(-left);
      end
      bta_pkg::A_W_S_ROOM: begin
        mem_we = 1'b1; mem_wdata = 32'(t_room);
      end
      bta_pkg::A_W_E_ROOM: begin
        mem_we = 1'b1; mem_pos = e_q; mem_wdata = 32'(t_room);
      end
      bta_pkg::A_ZERO: begin
        mem_we = 1'b1; mem_pos = wh_i;
      end
      bta_pkg::A_W_COPY: begin
        mem_we = 1'b1; mem_pos = wh_i; mem_wdata = rd;
      end
      bta_pkg::A_W_S_NEGT: begin
        mem_we = 1'b1; mem_wdata = -t_q;
      end
      bta_pkg::A_W_E_NEGT: begin
        mem_we = 1'b1; mem_pos = e_q; mem_wdata = -t_q;
      end
      bta_pkg::A_W_S_MRG: begin
        mem_we = 1'b1; mem_wdata = mrg_tag;
      end
      bta_pkg::A_W_E_MRG: begin
        mem_we = 1'b1; mem_pos = e_q; mem_wdata = mrg_tag;
      end
      bta_pkg::A_W_BA: begin
        mem_we = 1'b1; mem_pos = ba_x; mem_wdata = wd_q;
      end
      default: ;
    endcase
  end

  assign mem_addr = mem_pos[AW-1:0];

  bta_ram #(
    .Width (32),
    .Depth (HEAP_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (ram_rdata)
  );

  // Unused-heap overhead from the walk sums
  assign overhead = signed'((SUMW+1)'(HEAP_WORDS)) - signed'({1'b0, wa_q})
                    - signed'({1'b0, wv_q});

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.act)
      bta_pkg::A_LOAD: begin
        op_q        <= bta_pkg::op_e'(op_i);
        words_q     <= 15'((17'(size_bytes_i) + 17'd3) >> 2);
        ba_q        <= block_addr_i;
        wd_q        <= write_data_i;
        s_q         <= '0;
        i_q         <= '0;
        n_q         <= '0;
        where_q     <= '0;
        wa_q        <= '0;
        wv_q        <= '0;
        bu_q        <= '0;
        bf_q        <= '0;
        last_free_q <= 1'b0;
        rdata_q     <= '0;
      end
      bta_pkg::A_TAG: begin
        t_q <= rd;
        e_q <= s_q + rd_room + PW'(1);
        p_q <= s_q + rd_room + PW'(2);
      end
      bta_pkg::A_ADV_RD, bta_pkg::A_S_FROM_P: s_q <= p_q;
      bta_pkg::A_W_E_NLEFT: begin
        n_q     <= words_x;
        where_q <= s_q + PW'(1);
      end
      bta_pkg::A_W_E_ROOM: begin
        n_q     <= t_room;
        where_q <= s_q + PW'(1);
      end
      bta_pkg::A_ZERO, bta_pkg::A_W_COPY, bta_pkg::A_INC_I: i_q <= i_q + PW'(1);
      bta_pkg::A_SET_N_MIN: begin
        n_q <= (rd_room < n_q) ? rd_room : n_q;
        i_q <= '0;
      end
      bta_pkg::A_LD_S_BAM1: s_q <= ba_m1;
      bta_pkg::A_PREV:      p_q <= s_q - PW'(2) - rd_room;
      bta_pkg::A_LE:        e_q <= p_q + rd_room + PW'(1);
      bta_pkg::A_ACC: begin
        if (rd > 0) begin
          wa_q <= wa_q + SUMW'(rd_room);
          bu_q <= bu_q + CNTW'(1);
        end else begin
          wv_q <= wv_q + SUMW'(rd_room);
          bf_q <= bf_q + CNTW'(1);
        end
        p_q <= s_q + rd_room + PW'(2);
      end
      bta_pkg::A_CK_ADV: begin
        last_free_q <= (t_q < 0);
        s_q         <= e_q + PW'(1);
      end
      bta_pkg::A_LD_RDATA: rdata_q <= rd;
      default: ;
    endcase
    if (cmd_i.act == bta_pkg::A_LOAD) begin
      status_q <= bta_pkg::ST_OK;
    end else if (cmd_i.set_st) begin
      status_q <= cmd_i.st;
    end
    // Result payload
    if (cmd_i.act == bta_pkg::A_OUT) begin
      o_status_q <= status_q;
      o_addr_q   <= ((status_q == bta_pkg::ST_OK) && (op_q <= bta_pkg::OP_REALLOC))
                    ? where_q[9:0] : 10'd0;
      o_rdata_q  <= rdata_q;
      if (op_q == bta_pkg::OP_STATS) begin
        o_wa_q <= sat11(signed'({1'b0, wa_q}));
        o_wv_q <= sat11(signed'({1'b0, wv_q}));
        o_wo_q <= sat11(overhead);
        o_bu_q <= sat10(bu_q);
        o_bf_q <= sat10(bf_q);
      end else begin
        o_wa_q <= '0;
        o_wv_q <= '0;
        o_wo_q <= '0;
        o_bu_q <= '0;
        o_bf_q <= '0;
      end
    end
  end

  // Control registers: result valid and end-tag overlay
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      f0_q      <= 1'b1;
      fn_q      <= 1'b1;
      ovr_q     <= 1'b0;
    end else begin
      if (cmd_i.act == bta_pkg::A_OUT) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
      if (mem_we && (mem_addr == '0)) begin
        f0_q <= 1'b0;
      end
      if (mem_we && (mem_addr == LastAddr)) begin
        fn_q <= 1'b0;
      end
      ovr_q <= (f0_q && (mem_addr == '0)) || (fn_q && (mem_addr == LastAddr));
    end
  end

  assign out_valid_o       = o_valid_q;
  assign status_o          = o_status_q;
  assign addr_o            = o_addr_q;
  assign read_data_o       = o_rdata_q;
  assign words_allocated_o = o_wa_q;
  assign words_available_o = o_wv_q;
  assign words_overhead_o  = o_wo_q;
  assign blocks_used_o     = o_bu_q;
  assign blocks_unused_o   = o_bf_q;

endmodule

/* design/boundary_tag_heap_allocator_core.sv */
// Channel  Dir  Payload
// req      in   op, size_bytes, block_addr, write_data
// rsp      out  status, addr, read_data, words_*, blocks_*
//
// One transaction at a time; a result sits in the output register while the
// next request is taken. Request time depends on the operation: free on the
// merges, alloc, stats and check on the blocks walked; zeroed alloc adds one
// write per data word and realloc a read and a write per copied word; the
// single heap RAM port sets these.
// No clearing pass after reset: the two end tags come up free.
module boundary_tag_heap_allocator_core #(
  parameter int HEAP_WORDS = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bta_req_if.sink    req,
  bta_rsp_if.source  rsp
);

  bta_pkg::cmd_t   cmd;
  bta_pkg::flags_t flags;

  bta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  bta_dp #(
    .HEAP_WORDS (HEAP_WORDS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .flags_o           (flags),
    .op_i              (req.op),
    .size_bytes_i      (req.size_bytes),
    .block_addr_i      (req.block_addr),
    .write_data_i      (req.write_data),
    .out_ready_i       (rsp.ready),
    .out_valid_o       (rsp.valid),
    .status_o          (rsp.status),
    .addr_o            (rsp.addr),
    .read_data_o       (rsp.read_data),
    .words_allocated_o (rsp.words_allocated),
    .words_available_o (rsp.words_available),
    .words_overhead_o  (rsp.words_overhead),
    .blocks_used_o     (rsp.blocks_used),
    .blocks_unused_o   (rsp.blocks_unused)
  );

`ifndef SYNTHESIS
  // Failed operations never report an address
  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && (rsp.status != bta_pkg::ST_OK) |-> (rsp.addr == '0))
    else $error("address on failed result");

  // Read data only comes from a successful read
  a_rdata_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && (rsp.read_data != '0) |-> (rsp.status == bta_pkg::ST_OK))
    else $error("read data with error status");

  // One request in flight: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted back to back");
`endif

endmodule
